// ===== rtl/core/i2cm_pkg.sv =====
// Shared types and constants for the I2C register access master.
package i2cm_pkg;

	// Request codes carried in req_type.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_READ  = 2'd2;

	// Configuration register file.
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 8;
	localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT = 1'd1;

	localparam logic [7:0] DEV_ADDR_RESET   = 8'h26;
	localparam logic [7:0] POLL_LIMIT_RESET = 8'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [7:0] reg_addr;
		logic [7:0] write_data;
		logic       sda_in;
	} i2cm_in_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_result;
		logic       address_nack;
		logic       later_nack;
	} i2cm_out_t;

	typedef struct packed {
		logic [7:0] dev_addr;
		logic [7:0] poll_limit;
	} i2cm_cfg_t;

endpackage

// ===== rtl/core/i2cm_engine.sv =====
// Bus phase sequencer: advances one I2C phase per transfer and forms its result.
module i2cm_engine
	import i2cm_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  i2cm_in_t  item,
	input  i2cm_cfg_t cfg,
	output i2cm_out_t result
);

	typedef enum logic [4:0] {
		PH_IDLE    = 5'd0,
		PH_ST0     = 5'd1,
		PH_ST1     = 5'd2,
		PH_ST2     = 5'd3,
		PH_TXSET   = 5'd4,
		PH_TXHI    = 5'd5,
		PH_TXLO    = 5'd6,
		PH_ACKREL  = 5'd7,
		PH_ACKPOLL = 5'd8,
		PH_RXLO    = 5'd9,
		PH_RXHI    = 5'd10,
		PH_NK0     = 5'd11,
		PH_NK1     = 5'd12,
		PH_NK2     = 5'd13,
		PH_SP0     = 5'd14,
		PH_SP1     = 5'd15,
		PH_SP2     = 5'd16
	} phase_t;

	phase_t     phase_q, phase_nxt;
	logic [3:0] bit_q, bit_nxt;
	logic [7:0] shift_q, shift_nxt;
	logic [2:0] byte_step_q, byte_step_nxt;
	logic [7:0] poll_q, poll_nxt;
	logic       is_read_q, is_read_nxt;
	logic [7:0] reg_addr_q, reg_addr_nxt;
	logic [7:0] wdata_q, wdata_nxt;
	logic [1:0] nack_q, nack_nxt;
	logic       scl, sda, done;
	logic       ack_seen, poll_over;

	assign ack_seen  = ~item.sda_in;
	assign poll_over = poll_q >= cfg.poll_limit;

	always_comb begin
		phase_nxt     = phase_q;
		bit_nxt       = bit_q;
		shift_nxt     = shift_q;
		byte_step_nxt = byte_step_q;
		poll_nxt      = poll_q;
		is_read_nxt   = is_read_q;
		reg_addr_nxt  = reg_addr_q;
		wdata_nxt     = wdata_q;
		nack_nxt      = nack_q;
		scl           = 1'b1;
		sda           = 1'b1;
		done          = 1'b0;
		unique case (phase_q)
			PH_IDLE: begin
				if (item.req_type == REQ_WRITE || item.req_type == REQ_READ) begin
					is_read_nxt   = (item.req_type == REQ_READ);
					reg_addr_nxt  = item.reg_addr;
					wdata_nxt     = (item.req_type == REQ_WRITE) ? item.write_data : 8'd0;
					nack_nxt      = 2'b00;
					byte_step_nxt = 3'd0;
					bit_nxt       = 4'd0;
					poll_nxt      = 8'd0;
					shift_nxt     = 8'd0;
					phase_nxt     = PH_ST1;
				end
			end
			PH_ST0: phase_nxt = PH_ST1;
			PH_ST1: begin
				sda       = 1'b0;
				phase_nxt = PH_ST2;
			end
			PH_ST2: begin
				scl       = 1'b0;
				sda       = 1'b0;
				// second START of a read sends the address with bit zero set
				shift_nxt = (byte_step_q == 3'd2) ? {cfg.dev_addr[7:1], 1'b1}
				                                  : {cfg.dev_addr[7:1], 1'b0};
				bit_nxt   = 4'd0;
				phase_nxt = PH_TXSET;
			end
			PH_TXSET: begin
				sda       = shift_q[7];
				scl       = 1'b0;
				phase_nxt = PH_TXHI;
			end
			PH_TXHI: begin
				sda       = shift_q[7];
				phase_nxt = PH_TXLO;
			end
			PH_TXLO: begin
				sda       = shift_q[7];
				scl       = 1'b0;
				shift_nxt = {shift_q[6:0], 1'b0};
				if (bit_q >= 4'd7) begin
					bit_nxt   = 4'd0;
					phase_nxt = PH_ACKREL;
				end else begin
					bit_nxt   = bit_q + 4'd1;
					phase_nxt = PH_TXSET;
				end
			end
			PH_ACKREL: begin
				poll_nxt  = 8'd0;
				phase_nxt = PH_ACKPOLL;
			end
			PH_ACKPOLL: begin
				if (ack_seen || poll_over) begin
					scl = 1'b0;
					if (!ack_seen) begin
						if (byte_step_q == 3'd0) nack_nxt = nack_q | 2'b01;
						else nack_nxt = nack_q | 2'b10;
					end
					byte_step_nxt = byte_step_q + 3'd1;
					case (byte_step_q)
						3'd0: begin
							shift_nxt = reg_addr_q;
							bit_nxt   = 4'd0;
							phase_nxt = PH_TXSET;
						end
						3'd1: begin
							if (is_read_q) begin
								phase_nxt = PH_ST0;
							end else begin
								shift_nxt = wdata_q;
								bit_nxt   = 4'd0;
								phase_nxt = PH_TXSET;
							end
						end
						3'd2: begin
							if (is_read_q) begin
								shift_nxt = 8'd0;
								bit_nxt   = 4'd0;
								phase_nxt = PH_RXLO;
							end else begin
								phase_nxt = PH_SP0;
							end
						end
						default: phase_nxt = PH_SP0;
					endcase
				end else begin
					poll_nxt = poll_q + 8'd1;
				end
			end
			PH_RXLO: begin
				scl       = 1'b0;
				phase_nxt = PH_RXHI;
			end
			PH_RXHI: begin
				shift_nxt = {shift_q[6:0], item.sda_in};
				if (bit_q >= 4'd7) begin
					bit_nxt   = 4'd0;
					phase_nxt = PH_NK0;
				end else begin
					bit_nxt   = bit_q + 4'd1;
					phase_nxt = PH_RXLO;
				end
			end
			PH_NK0: begin
				scl       = 1'b0;
				phase_nxt = PH_NK1;
			end
			PH_NK1: phase_nxt = PH_NK2;
			PH_NK2: begin
				scl       = 1'b0;
				phase_nxt = PH_SP0;
			end
			PH_SP0: begin
				scl       = 1'b0;
				sda       = 1'b0;
				phase_nxt = PH_SP1;
			end
			PH_SP1: begin
				sda       = 1'b0;
				phase_nxt = PH_SP2;
			end
			PH_SP2: begin
				done      = 1'b1;
				phase_nxt = PH_IDLE;
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	always_comb begin
		result.scl_level    = scl;
		result.sda_level    = sda;
		result.busy_res     = (phase_nxt != PH_IDLE);
		result.done_res     = done;
		result.read_result  = (done && is_read_nxt) ? shift_nxt : 8'd0;
		result.address_nack = done & nack_nxt[0];
		result.later_nack   = done & nack_nxt[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_q       <= '0;
			shift_q     <= '0;
			byte_step_q <= '0;
			poll_q      <= '0;
			is_read_q   <= 1'b0;
			reg_addr_q  <= '0;
			wdata_q     <= '0;
			nack_q      <= '0;
		end else if (step) begin
			phase_q     <= phase_nxt;
			bit_q       <= bit_nxt;
			shift_q     <= shift_nxt;
			byte_step_q <= byte_step_nxt;
			poll_q      <= poll_nxt;
			is_read_q   <= is_read_nxt;
			reg_addr_q  <= reg_addr_nxt;
			wdata_q     <= wdata_nxt;
			nack_q      <= nack_nxt;
		end
	end

endmodule

// ===== rtl/core/i2c_master_register_access.sv =====
// Top level of the I2C single-register access master.
//
// Usage: every item on the item channel is one tick of the bus engine. A tick
// with req_type write or read while the engine is idle latches reg_addr (and
// write_data) and starts a transaction; any other tick advances a busy bus one
// phase, sampling sda_in where the phase looks at SDA. Every item yields
// exactly one result on the result channel carrying the SCL/SDA drive levels,
// busy, and on the STOP tick done with the read byte and the NACK flags.
// An accepted item is held in the input register, the engine evaluates it
// there, and its result is captured in the result register until transferred.
// Throughput: one item per cycle while the result side does not stall; the input
// and result registers are separate stages, and the single-pass phase logic sets it.
// When the result side stalls, the input register holds its item and
// item_ready drops only once both stages are full; no state advances and no
// transfer is lost. Reset (arst_n low) returns the engine to idle with both
// lines released, empties both stages and loads the configuration registers
// with address byte 0x26 and poll limit 2. Write cfg_we/cfg_index/cfg_wdata
// only while no transfer is in flight.
module i2c_master_register_access
	import i2cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_ready,
	input  i2cm_in_t              item,
	output logic                  result_valid,
	input  logic                  result_ready,
	output i2cm_out_t             result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	i2cm_in_t  item_s1;
	logic      valid_s1;
	i2cm_out_t result_s2;
	logic      valid_s2;
	i2cm_out_t eng_result;
	i2cm_cfg_t cfg_q;
	logic      advance;
	logic      step;

	// Result register frees when empty or being taken this cycle.
	assign advance    = !valid_s2 || result_ready;
	assign step       = valid_s1 && advance;
	assign item_ready = !valid_s1 || advance;

	// Configuration registers: write only, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dev_addr   <= DEV_ADDR_RESET;
			cfg_q.poll_limit <= POLL_LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEV_ADDR:   cfg_q.dev_addr   <= cfg_wdata;
				CFG_POLL_LIMIT: cfg_q.poll_limit <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input stage: load on every accepted transfer, drop when handed on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Phase engine evaluates the input stage item and advances on step.
	i2cm_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (eng_result)
	);

	// Result stage: hold while the receiver stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_s2 <= eng_result;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

`ifndef NO_ASSERTIONS
	// An accepted transfer always lands in the input stage.
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> valid_s1)
		else $error("accepted transfer did not reach the input stage");

	// A stalled full pipeline must refuse new transfers.
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |-> !item_ready)
		else $error("item accepted while both stages full and stalled");

	// Done marks the return to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.done_res |-> !result.busy_res)
		else $error("done reported while still busy");

	// Read byte and flags stay zero off the STOP tick.
	a_flags_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.done_res |->
			result.read_result == 8'd0 && !result.address_nack && !result.later_nack)
		else $error("status fields set without done");

	// When idle both lines are released.
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |-> result.scl_level && result.sda_level)
		else $error("bus line driven while idle");
`endif

endmodule

// ===== dv/tb_i2c_master_register_access.sv =====
// Self-checking testbench for the I2C register access master: tick-level bus model and checks.
module tb_i2c_master_register_access;
	import i2cm_pkg::*;

	// Request code that the engine treats as a plain tick.
	localparam logic [1:0] REQ_SPARE = 2'd3;

	// Clock period is 12 units; the timeout is far above the slowest legal run.
	localparam int unsigned TIMEOUT_CYCLES = 400000;
	localparam int unsigned SETTLE_CYCLES  = 4;
	localparam int unsigned MAX_REPORTS    = 50;

	// Bus phases of the engine, in the order the engine numbers them.
	typedef enum logic [4:0] {
		BP_IDLE, BP_ST0, BP_ST1, BP_ST2, BP_TXSET, BP_TXHI, BP_TXLO, BP_ACKREL,
		BP_ACKPOLL, BP_RXLO, BP_RXHI, BP_NK0, BP_NK1, BP_NK2, BP_SP0, BP_SP1, BP_SP2
	} bus_phase_t;

	typedef struct packed {
		bus_phase_t phase;
		logic [3:0] bits;
		logic [7:0] shreg;
		logic [2:0] step;
		logic [7:0] polls;
		logic       rd;
		logic [7:0] raddr;
		logic [7:0] wdata;
		logic [1:0] nack;
	} bus_state_t;

	// How the simulated slave answers acknowledge polls within one transaction.
	typedef enum {ACK_FAST, ACK_SLOW, ACK_MIXED, ACK_NONE, ACK_ADDR_NONE} ack_mode_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  item_valid   = 1'b0;
	logic                  item_ready;
	i2cm_in_t              item         = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	i2cm_out_t             result;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata    = '0;

	// Configuration copy shared by the planner and the checker; changes only while idle.
	logic [7:0] dev_addr_cfg   = DEV_ADDR_RESET;
	logic [7:0] poll_limit_cfg = POLL_LIMIT_RESET;

	// The planner runs ahead of the block to shape sequences; the checker follows transfers.
	bus_state_t plan_st  = '0;
	bus_state_t model_st = '0;

	i2cm_in_t  tick_queue[$];
	i2cm_out_t due_outputs[$];

	int unsigned planned_items = 0;
	int unsigned issued_cnt    = 0;
	int unsigned accepted_cnt  = 0;
	int unsigned mismatches    = 0;
	int unsigned txn_done_cnt  = 0;
	int unsigned read_done_cnt = 0;
	int unsigned addr_nack_cnt = 0;
	int unsigned data_nack_cnt = 0;
	int unsigned settings_cnt  = 1;

	i2c_master_register_access u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Pick the byte that follows an acknowledge, once the poll has resolved.
	function automatic void next_byte(inout bus_state_t s);
		logic [2:0] cur;
		cur = s.step;
		s.step = s.step + 3'd1;
		if (cur == 3'd0) begin
			s.shreg = s.raddr;
			s.bits = '0;
			s.phase = BP_TXSET;
		end else if (cur == 3'd1) begin
			// Reads go back through a repeated START for the read address.
			if (s.rd) begin
				s.phase = BP_ST0;
			end else begin
				s.shreg = s.wdata;
				s.bits = '0;
				s.phase = BP_TXSET;
			end
		end else if (cur == 3'd2 && s.rd) begin
			s.shreg = '0;
			s.bits = '0;
			s.phase = BP_RXLO;
		end else begin
			s.phase = BP_SP0;
		end
	endfunction

	// Advance the bus by one item and return the line drive and status it leaves.
	function automatic i2cm_out_t bus_step(inout bus_state_t s, input logic [7:0] dev,
			input logic [7:0] lim, input i2cm_in_t it);
		i2cm_out_t o;
		logic scl;
		logic sda;
		logic done;
		scl = 1'b1;
		sda = 1'b1;
		done = 1'b0;
		case (s.phase)
			BP_IDLE: begin
				// Latch a request; START begins on the next tick. Anything else is ignored.
				if (it.req_type == REQ_WRITE || it.req_type == REQ_READ) begin
					s.rd = (it.req_type == REQ_READ);
					s.raddr = it.reg_addr;
					s.wdata = s.rd ? 8'h00 : it.write_data;
					s.nack = '0;
					s.step = '0;
					s.bits = '0;
					s.polls = '0;
					s.shreg = '0;
					s.phase = BP_ST1;
				end
			end
			BP_ST0: s.phase = BP_ST1;
			BP_ST1: begin
				sda = 1'b0;
				s.phase = BP_ST2;
			end
			BP_ST2: begin
				scl = 1'b0;
				sda = 1'b0;
				// Force bit zero: set for the read address, clear for the write address.
				s.shreg = (s.step == 3'd2) ? (dev | 8'h01) : (dev & 8'hFE);
				s.bits = '0;
				s.phase = BP_TXSET;
			end
			BP_TXSET: begin
				sda = s.shreg[7];
				scl = 1'b0;
				s.phase = BP_TXHI;
			end
			BP_TXHI: begin
				sda = s.shreg[7];
				s.phase = BP_TXLO;
			end
			BP_TXLO: begin
				sda = s.shreg[7];
				scl = 1'b0;
				s.shreg = {s.shreg[6:0], 1'b0};
				s.bits = s.bits + 4'd1;
				if (s.bits >= 4'd8) begin
					s.bits = '0;
					s.phase = BP_ACKREL;
				end else begin
					s.phase = BP_TXSET;
				end
			end
			BP_ACKREL: begin
				s.polls = '0;
				s.phase = BP_ACKPOLL;
			end
			BP_ACKPOLL: begin
				if (!it.sda_in) begin
					scl = 1'b0;
					next_byte(s);
				end else if (s.polls >= lim) begin
					// Out of patience: flag the NACK and carry on with the transfer.
					scl = 1'b0;
					s.nack = s.nack | ((s.step == 3'd0) ? 2'b01 : 2'b10);
					next_byte(s);
				end else begin
					s.polls = s.polls + 8'd1;
				end
			end
			BP_RXLO: begin
				scl = 1'b0;
				s.phase = BP_RXHI;
			end
			BP_RXHI: begin
				s.shreg = {s.shreg[6:0], it.sda_in};
				s.bits = s.bits + 4'd1;
				if (s.bits >= 4'd8) begin
					s.bits = '0;
					s.phase = BP_NK0;
				end else begin
					s.phase = BP_RXLO;
				end
			end
			BP_NK0: begin
				scl = 1'b0;
				s.phase = BP_NK1;
			end
			BP_NK1: s.phase = BP_NK2;
			BP_NK2: begin
				scl = 1'b0;
				s.phase = BP_SP0;
			end
			BP_SP0: begin
				scl = 1'b0;
				sda = 1'b0;
				s.phase = BP_SP1;
			end
			BP_SP1: begin
				sda = 1'b0;
				s.phase = BP_SP2;
			end
			BP_SP2: begin
				done = 1'b1;
				s.phase = BP_IDLE;
			end
			default: s.phase = BP_IDLE;
		endcase
		o.scl_level    = scl;
		o.sda_level    = sda;
		o.busy_res     = (s.phase != BP_IDLE);
		o.done_res     = done;
		o.read_result  = (done && s.rd) ? s.shreg : 8'h00;
		o.address_nack = done & s.nack[0];
		o.later_nack   = done & s.nack[1];
		return o;
	endfunction

	// Queue one item for the driver and run it through the planner.
	task automatic queue_item(input i2cm_in_t it);
		i2cm_out_t ignored;
		tick_queue.push_back(it);
		ignored = bus_step(plan_st, dev_addr_cfg, poll_limit_cfg, it);
		planned_items++;
	endtask

	// Queue a request and enough ticks to walk it through STOP.
	task automatic run_txn(input logic [1:0] req, input logic [7:0] ra, input logic [7:0] wd,
			input ack_mode_t mode);
		i2cm_in_t it;
		it.req_type   = req;
		it.reg_addr   = ra;
		it.write_data = wd;
		it.sda_in     = 1'($urandom_range(0, 1));
		queue_item(it);
		while (plan_st.phase != BP_IDLE) begin
			// Sprinkle requests in while busy; the engine must treat them as ticks.
			it.req_type   = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : REQ_TICK;
			it.reg_addr   = 8'($urandom_range(0, 255));
			it.write_data = 8'($urandom_range(0, 255));
			if (plan_st.phase == BP_ACKPOLL) begin
				case (mode)
					ACK_FAST:      it.sda_in = 1'b0;
					ACK_SLOW:      it.sda_in = ($urandom_range(0, 3) != 0);
					ACK_MIXED:     it.sda_in = 1'($urandom_range(0, 1));
					// Silent on the first address byte only, prompt afterwards.
					ACK_ADDR_NONE: it.sda_in = (plan_st.step == 3'd0);
					default:       it.sda_in = 1'b1;
				endcase
			end else begin
				it.sda_in = 1'($urandom_range(0, 1));
			end
			queue_item(it);
		end
	endtask

	task automatic queue_idle_tick(input logic [1:0] req, input logic [7:0] fill, input logic sda);
		i2cm_in_t it;
		it.req_type   = req;
		it.reg_addr   = fill;
		it.write_data = fill;
		it.sda_in     = sda;
		queue_item(it);
	endtask

	// Fill with random transactions until about n items have been planned.
	task automatic random_fill(input int unsigned n);
		int unsigned start;
		ack_mode_t mode;
		start = planned_items;
		while (planned_items - start < n) begin
			// A silent slave is only affordable while the poll limit is short.
			if (poll_limit_cfg > 8'd40) mode = ack_mode_t'($urandom_range(0, 2));
			else mode = ack_mode_t'($urandom_range(0, 3));
			run_txn($urandom_range(0, 1) ? REQ_READ : REQ_WRITE, 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), mode);
			repeat ($urandom_range(0, 2))
				queue_idle_tick(($urandom_range(0, 3) == 0) ? REQ_SPARE : REQ_TICK,
					8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
	endtask

	// Hold until every queued item has been transferred and answered, then let the block settle.
	task automatic wait_quiet;
		while (tick_queue.size() != 0 || issued_cnt != accepted_cnt || due_outputs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Write the address byte register and then the poll limit register; only called while the block is idle.
	task automatic write_config(input logic [7:0] dev, input logic [7:0] lim);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEV_ADDR;
		cfg_wdata <= dev;
		@(negedge clk);
		cfg_index <= CFG_POLL_LIMIT;
		cfg_wdata <= lim;
		dev_addr_cfg = dev;
		poll_limit_cfg = lim;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_cnt++;
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			if (mismatches < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Driver: present queued items in bursts; advance only after the current transfer.
	int unsigned burst_left = 0;
	int unsigned gap_left   = 0;

	always @(negedge clk) begin
		if (arst_n && accepted_cnt == issued_cnt) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (tick_queue.size() > 0) begin
				item <= tick_queue.pop_front();
				item_valid <= 1'b1;
				issued_cnt++;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					// New burst; about a third of them follow with no gap at all.
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: short stalls, long ready runs, and a long hold-off now and then so
	// that both stages fill and item_ready drops while the driver keeps offering.
	int unsigned rx_cycle = 0;
	int unsigned hold_left = 0;
	int unsigned run_left = 0;
	int unsigned stall_left = 0;

	always @(negedge clk) begin
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			result_ready <= 1'b0;
		end else if (rx_cycle % 1500 == 700) begin
			hold_left = $urandom_range(40, 80);
			result_ready <= 1'b0;
		end else if (run_left > 0) begin
			run_left--;
			result_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else begin
			run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 8);
			stall_left = $urandom_range(0, 4);
			result_ready <= 1'b1;
		end
	end

	// Monitor: check each result transfer against the oldest prediction, then predict
	// for an item transferred at this edge.
	i2cm_out_t want;
	i2cm_out_t pred;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (due_outputs.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: result with nothing expected, actual %0h", $time, result);
					mismatches++;
				end else begin
					want = due_outputs.pop_front();
					check_field("scl_level", 32'(want.scl_level), 32'(result.scl_level));
					check_field("sda_level", 32'(want.sda_level), 32'(result.sda_level));
					check_field("busy_res", 32'(want.busy_res), 32'(result.busy_res));
					check_field("done_res", 32'(want.done_res), 32'(result.done_res));
					check_field("read_result", 32'(want.read_result),
						32'(result.read_result));
					check_field("address_nack", 32'(want.address_nack),
						32'(result.address_nack));
					check_field("later_nack", 32'(want.later_nack), 32'(result.later_nack));
					if (want.done_res) begin
						txn_done_cnt++;
						addr_nack_cnt += 32'(want.address_nack);
						data_nack_cnt += 32'(want.later_nack);
					end
				end
			end
			if (item_valid && item_ready) begin
				pred = bus_step(model_st, dev_addr_cfg, poll_limit_cfg, item);
				if (pred.done_res && model_st.rd) read_done_cnt++;
				due_outputs.push_back(pred);
				accepted_cnt++;
			end
		end
	end

	initial begin
		#(12 * TIMEOUT_CYCLES);
		$display("i2c_master_register_access verification failed");
		$finish;
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: address byte 0x26, poll limit 2.
		queue_idle_tick(REQ_TICK, 8'hFF, 1'b1);
		queue_idle_tick(REQ_SPARE, 8'h00, 1'b0);
		run_txn(REQ_WRITE, 8'h00, 8'hFF, ACK_FAST);
		run_txn(REQ_READ, 8'hFF, 8'h00, ACK_FAST);
		run_txn(REQ_WRITE, 8'hFF, 8'h00, ACK_NONE);
		run_txn(REQ_READ, 8'hA5, 8'h5A, ACK_NONE);
		run_txn(REQ_WRITE, 8'h5A, 8'hC3, ACK_SLOW);
		run_txn(REQ_READ, 8'h3C, 8'hFF, ACK_MIXED);
		random_fill(100);
		wait_quiet();

		// Zero address and zero poll limit: the first high sample is a NACK.
		write_config(8'h00, 8'd0);
		run_txn(REQ_READ, 8'h81, 8'h7E, ACK_FAST);
		run_txn(REQ_WRITE, 8'h7E, 8'h81, ACK_MIXED);
		random_fill(60);
		wait_quiet();

		// All-ones address forces bit zero clear on writes; full poll limit never wraps.
		write_config(8'hFF, 8'd255);
		run_txn(REQ_WRITE, 8'h55, 8'hAA, ACK_ADDR_NONE);
		random_fill(60);
		wait_quiet();

		// Odd address byte with a mid-range limit.
		write_config(8'h27, 8'd7);
		random_fill(120);
		wait_quiet();

		// Random settings, mostly with short limits so that NACKs keep appearing.
		repeat (3) begin
			write_config(8'($urandom_range(0, 255)),
				$urandom_range(0, 1) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 6)));
			random_fill(40);
			wait_quiet();
		end

		$display("Ran %0d item transfers and %0d transactions (%0d reads) over %0d settings.",
			accepted_cnt, txn_done_cnt, read_done_cnt, settings_cnt);
		$display("NACKs reported: %0d on the first address byte, %0d on later bytes.",
			addr_nack_cnt, data_nack_cnt);
		if (mismatches == 0 && due_outputs.size() == 0) begin
			$display("i2c_master_register_access verification clean");
		end else begin
			$display("i2c_master_register_access verification failed");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_engine.sv
rtl/core/i2c_master_register_access.sv
dv/tb_i2c_master_register_access.sv
